FILE: hw/rtl/bir_pkg.sv
package bir_pkg;

  localparam int MAX_SRC_ROWS = 256;
  localparam int MAX_SRC_COLS = 256;
  localparam int FRAC_BITS    = 16;

  localparam int PIX_W   = 8;
  localparam int IDX_W   = 12;
  localparam int SIZE_W  = 9;
  localparam int STEP_W  = 25;
  localparam int CFG_W   = 25;
  localparam int CFG_IDX_W = 2;

  localparam int ROW_W   = $clog2(MAX_SRC_ROWS);
  localparam int COL_W   = $clog2(MAX_SRC_COLS);
  localparam int LIDX_W  = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int DEPTH   = MAX_SRC_ROWS * MAX_SRC_COLS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int POS_W   = IDX_W + STEP_W;
  localparam int WHOLE_W = POS_W - FRAC_BITS;

  localparam logic REQ_STORE   = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP   = 2'd3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
  localparam logic [STEP_W-1:0] STEP_RESET = 25'd65536;

  typedef struct packed {
    logic [LIDX_W-1:0]    idx;
    logic [FRAC_BITS-1:0] frac;
    logic                 clamped;
    logic                 at_last;
  } loc_t;

  function automatic int unsigned last_of(logic [SIZE_W-1:0] size, int unsigned max_sz);
    int unsigned s;
    s = 32'(size);
    if (s == 0) s = 1;
    if (s > max_sz) s = max_sz;
    return s - 1;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    int unsigned a;
    a = 32'(row) * MAX_SRC_COLS + 32'(col);
    return a[ADDR_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/bir_if.sv
interface bir_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [bir_pkg::IDX_W-1:0]     row_index;
  logic [bir_pkg::IDX_W-1:0]     col_index;
  logic [bir_pkg::PIX_W-1:0]     pixel_in;

  modport source (output valid, input ready, output req_type, output row_index,
                  output col_index, output pixel_in);
  modport sink (input valid, output ready, input req_type, input row_index,
                input col_index, input pixel_in);
endinterface

interface bir_out_if;
  logic                          valid;
  logic                          ready;
  logic [bir_pkg::PIX_W-1:0]     pixel_out;
  logic                          clamped;

  modport source (output valid, input ready, output pixel_out, output clamped);
  modport sink (input valid, output ready, input pixel_out, input clamped);
endinterface

FILE: hw/rtl/bir_ram.sv
module bir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic [WIDTH-1:0]         ra_data,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

FILE: hw/rtl/bir_locate.sv
module bir_locate (
  input  logic [bir_pkg::POS_W-1:0]  pos,
  input  logic [bir_pkg::LIDX_W-1:0] last,
  output bir_pkg::loc_t              loc
);

  logic [bir_pkg::WHOLE_W-1:0] whole;
  logic                        beyond;

  assign whole  = pos[bir_pkg::POS_W-1:bir_pkg::FRAC_BITS];
  assign beyond = whole > bir_pkg::WHOLE_W'(last);

  always_comb begin
    if (beyond) begin
      loc.idx     = last;
      loc.frac    = '0;
      loc.clamped = 1'b1;
      loc.at_last = 1'b1;
    end else begin
      loc.idx     = whole[bir_pkg::LIDX_W-1:0];
      loc.frac    = pos[bir_pkg::FRAC_BITS-1:0];
      loc.clamped = 1'b0;
      loc.at_last = whole == bir_pkg::WHOLE_W'(last);
    end
  end

endmodule

FILE: hw/rtl/bir_lerp.sv
module bir_lerp (
  input  logic [bir_pkg::PIX_W-1:0]     base,
  input  logic [bir_pkg::PIX_W-1:0]     other,
  input  logic [bir_pkg::FRAC_BITS-1:0] frac,
  output logic [bir_pkg::PIX_W-1:0]     result
);

  logic [bir_pkg::PIX_W:0]                    diff;
  logic [bir_pkg::PIX_W:0]                    ndiff;
  logic                                       neg;
  logic [bir_pkg::PIX_W-1:0]                  mag;
  logic [bir_pkg::FRAC_BITS+bir_pkg::PIX_W-1:0] prod;
  logic [bir_pkg::PIX_W-1:0]                  wgt;

  assign diff  = {1'b0, other} - {1'b0, base};
  assign ndiff = -diff;
  assign neg   = diff[bir_pkg::PIX_W];
  assign mag   = neg ? ndiff[bir_pkg::PIX_W-1:0] : diff[bir_pkg::PIX_W-1:0];
  assign prod  = (bir_pkg::FRAC_BITS+bir_pkg::PIX_W)'(frac)
               * (bir_pkg::FRAC_BITS+bir_pkg::PIX_W)'(mag);
  assign wgt   = prod[bir_pkg::FRAC_BITS+bir_pkg::PIX_W-1:bir_pkg::FRAC_BITS];
  assign result = neg ? base - wgt : base + wgt;

endmodule

FILE: hw/rtl/bilinear_image_resize.sv
// Store word: written to the pixel store at the accepting edge, no result.
// Compute word: no new word is taken until its result loads, which waits while one is held.
// The rate follows the two read ports of the pixel store (four neighbors in two
// reads) behind the position multiply and clamp stages.
// Reset (synchronous, rst_n low) clears control and restores register defaults;
// pixel store contents are undefined until written.
module bilinear_image_resize (
  input  logic                             clk,
  input  logic                             rst_n,
  bir_in_if.sink                           in_ch,
  bir_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [bir_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bir_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_LOC  = 3'd2;
  localparam logic [2:0] ST_RD0  = 3'd3;
  localparam logic [2:0] ST_RD1  = 3'd4;
  localparam logic [2:0] ST_HOR  = 3'd5;
  localparam logic [2:0] ST_VER  = 3'd6;

  logic [2:0]                       state_r, state_nxt;
  logic [bir_pkg::SIZE_W-1:0]       src_rows_r, src_cols_r;
  logic [bir_pkg::STEP_W-1:0]       x_step_r, y_step_r;
  logic [bir_pkg::IDX_W-1:0]        row_r, col_r;
  logic [bir_pkg::POS_W-1:0]        pos_y_r, pos_x_r;
  bir_pkg::loc_t                    loc_y, loc_x, loc_y_r, loc_x_r;
  logic [bir_pkg::PIX_W-1:0]        a_r, b_r, c_r, h0_r, h1_r;
  logic                             out_valid_r;
  logic [bir_pkg::PIX_W-1:0]        out_pixel_r;
  logic                             out_clamped_r;

  int unsigned                      rlast_full, clast_full;
  logic [bir_pkg::ROW_W-1:0]        rlast, ii, ii_n;
  logic [bir_pkg::COL_W-1:0]        clast, jj, jj_n;
  logic                             in_fire, out_fire, out_load, store_ok;
  logic [bir_pkg::ADDR_W-1:0]       ra_addr, rb_addr;
  logic [bir_pkg::PIX_W-1:0]        ra_data, rb_data;
  logic [bir_pkg::PIX_W-1:0]        h0, h1, v_base, v_other, v_res;

  assign in_ch.ready      = state_r == ST_IDLE;
  assign in_fire          = in_ch.valid && in_ch.ready;
  assign out_fire         = out_valid_r && out_ch.ready;
  assign out_load         = (state_r == ST_VER) && (!out_valid_r || out_ch.ready);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.pixel_out = out_pixel_r;
  assign out_ch.clamped   = out_clamped_r;

  assign rlast_full = bir_pkg::last_of(src_rows_r, bir_pkg::MAX_SRC_ROWS);
  assign clast_full = bir_pkg::last_of(src_cols_r, bir_pkg::MAX_SRC_COLS);
  assign rlast      = rlast_full[bir_pkg::ROW_W-1:0];
  assign clast      = clast_full[bir_pkg::COL_W-1:0];

  assign store_ok = (32'(in_ch.row_index) < bir_pkg::MAX_SRC_ROWS)
                 && (32'(in_ch.col_index) < bir_pkg::MAX_SRC_COLS);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_rows_r <= bir_pkg::SIZE_RESET;
      src_cols_r <= bir_pkg::SIZE_RESET;
      x_step_r   <= bir_pkg::STEP_RESET;
      y_step_r   <= bir_pkg::STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bir_pkg::CFG_SRC_ROWS: src_rows_r <= cfg_wdata[bir_pkg::SIZE_W-1:0];
        bir_pkg::CFG_SRC_COLS: src_cols_r <= cfg_wdata[bir_pkg::SIZE_W-1:0];
        bir_pkg::CFG_X_STEP:   x_step_r   <= cfg_wdata[bir_pkg::STEP_W-1:0];
        bir_pkg::CFG_Y_STEP:   y_step_r   <= cfg_wdata[bir_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_ch.req_type == bir_pkg::REQ_COMPUTE) state_nxt = ST_MUL;
      end
      ST_MUL:  state_nxt = ST_LOC;
      ST_LOC:  state_nxt = ST_RD0;
      ST_RD0:  state_nxt = ST_RD1;
      ST_RD1:  state_nxt = ST_HOR;
      ST_HOR:  state_nxt = ST_VER;
      ST_VER: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  bir_locate u_loc_y (
    .pos  (pos_y_r),
    .last (bir_pkg::LIDX_W'(rlast)),
    .loc  (loc_y)
  );

  bir_locate u_loc_x (
    .pos  (pos_x_r),
    .last (bir_pkg::LIDX_W'(clast)),
    .loc  (loc_x)
  );

  assign ii   = loc_y_r.idx[bir_pkg::ROW_W-1:0];
  assign jj   = loc_x_r.idx[bir_pkg::COL_W-1:0];
  assign ii_n = ii + 1'b1;
  assign jj_n = jj + 1'b1;

  always_comb begin
    if (state_r == ST_RD0) begin
      ra_addr = bir_pkg::addr_of(ii, jj);
      rb_addr = bir_pkg::addr_of(ii, jj_n);
    end else begin
      ra_addr = bir_pkg::addr_of(ii_n, jj);
      rb_addr = bir_pkg::addr_of(ii_n, jj_n);
    end
  end

  bir_ram #(
    .WIDTH (bir_pkg::PIX_W),
    .DEPTH (bir_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (in_fire && in_ch.req_type == bir_pkg::REQ_STORE && store_ok),
    .waddr   (bir_pkg::addr_of(in_ch.row_index[bir_pkg::ROW_W-1:0],
                               in_ch.col_index[bir_pkg::COL_W-1:0])),
    .wdata   (in_ch.pixel_in),
    .ra_addr (ra_addr),
    .ra_data (ra_data),
    .rb_addr (rb_addr),
    .rb_data (rb_data)
  );

  bir_lerp u_h0 (.base(a_r),     .other(b_r),     .frac(loc_x_r.frac), .result(h0));
  bir_lerp u_h1 (.base(ra_data), .other(rb_data), .frac(loc_x_r.frac), .result(h1));

  always_comb begin
    case ({loc_y_r.at_last, loc_x_r.at_last})
      2'b00:   begin v_base = h0_r; v_other = h1_r; end
      2'b01:   begin v_base = a_r;  v_other = c_r;  end
      2'b10:   begin v_base = h0_r; v_other = h0_r; end
      default: begin v_base = a_r;  v_other = a_r;  end
    endcase
  end

  bir_lerp u_v (.base(v_base), .other(v_other), .frac(loc_y_r.frac), .result(v_res));

  always_ff @(posedge clk) begin
    if (in_fire) begin
      row_r <= in_ch.row_index;
      col_r <= in_ch.col_index;
    end
    if (state_r == ST_MUL) begin
      pos_y_r <= bir_pkg::POS_W'(row_r) * bir_pkg::POS_W'(y_step_r);
      pos_x_r <= bir_pkg::POS_W'(col_r) * bir_pkg::POS_W'(x_step_r);
    end
    if (state_r == ST_LOC) begin
      loc_y_r <= loc_y;
      loc_x_r <= loc_x;
    end
    if (state_r == ST_RD1) begin
      a_r <= ra_data;
      b_r <= rb_data;
    end
    if (state_r == ST_HOR) begin
      h0_r <= h0;
      h1_r <= h1;
      c_r  <= ra_data;
    end
    if (out_load) begin
      out_pixel_r   <= v_res;
      out_clamped_r <= loc_y_r.clamped || loc_x_r.clamped;
    end
  end

  a_ver_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_VER && (!out_valid_r || out_ch.ready))
      |=> (state_r == ST_IDLE && out_valid_r))
    else $error("finished word not loaded into output register");

  a_store_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.req_type == bir_pkg::REQ_STORE && !out_valid_r) |=> !out_valid_r)
    else $error("store word produced a result");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.req_type == bir_pkg::REQ_COMPUTE) |=> !in_ch.ready)
    else $error("input taken while compute word in flight");

endmodule
